[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/fwd_pkg.sv]
// Types and constants of the firmware stream decompressor.
`default_nettype none
package fwd_pkg;

    localparam int COUNT_BITS = 24;
    localparam int LIMIT_BITS = 24;
    localparam int CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    localparam int PAT_DEPTH  = 65;
    localparam int PAT_AW     = $clog2(PAT_DEPTH);
    localparam int PAT_CW     = $clog2(PAT_DEPTH + 1);
    localparam int REM_BITS   = 15;
    localparam int PASS_BITS  = 9;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '1;

    // Command type in the top two bits of a command byte.
    localparam logic [1:0] CMD_REPEAT = 2'b00;
    localparam logic [1:0] CMD_BLOCK  = 2'b01;
    localparam logic [1:0] CMD_LRUN   = 2'b10;
    localparam logic [1:0] CMD_SRUN   = 2'b11;

    localparam logic [REM_BITS-1:0]  BLK_LONG_BIAS  = REM_BITS'(8'h21);
    localparam logic [REM_BITS-1:0]  LRUN_BIAS      = REM_BITS'(8'h42);
    localparam logic [REM_BITS-1:0]  BLK_SHORT_BIAS = REM_BITS'(1);
    localparam logic [REM_BITS-1:0]  SRUN_BIAS      = REM_BITS'(2);
    localparam logic [PAT_CW-1:0]    PAT_LEN_BIAS   = PAT_CW'(2);
    localparam logic [PASS_BITS-1:0] PASS_BIAS      = PASS_BITS'(2);

    localparam logic KIND_FEED = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    typedef enum logic [3:0] {
        PH_CMD,
        PH_REP_COUNT,
        PH_REP_PAT,
        PH_REP_EMIT,
        PH_BLK_LEN,
        PH_BLK_PAD,
        PH_BLK_DATA,
        PH_LR_LEN,
        PH_LR_VAL,
        PH_SR_VAL,
        PH_RUN_EMIT,
        PH_DONE,
        PH_TRUNC
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_NEED  = 3'd1,
        ST_PEND  = 3'd2,
        ST_DONE  = 3'd3,
        ST_TRUNC = 3'd4
    } t_status;

    // Result of one item; use_mem selects the pattern memory read data as byte.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       use_mem;
        logic       out_valid;
        logic       out_last;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [PAT_AW-1:0] addr;
        logic [7:0]        wr_data;
    } t_mem_req;

endpackage
`default_nettype wire

[hdl/fwd_pat_ram.sv]
// Simple dual-port RAM with registered read data.
`default_nettype none
module fwd_pat_ram #(
    parameter int DEPTH = 65,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

[hdl/fwd_ctrl.sv]
// Command decoder and stream state update, one item per cycle in which i_fire is high.
`default_nettype none
module fwd_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire logic                            i_kind,
    input  wire logic [7:0]                      i_in_byte,
    input  wire logic                            i_in_last,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [fwd_pkg::LIMIT_BITS-1:0]  i_cfg_wr_data,
    output fwd_pkg::t_result                     o_res,
    output fwd_pkg::t_mem_req                    o_mem
);

    fwd_pkg::t_phase                   r_phase, n_phase;
    logic [7:0]                        r_cmd, n_cmd;
    logic [fwd_pkg::REM_BITS-1:0]      r_rem, n_rem;
    logic [fwd_pkg::PASS_BITS-1:0]     r_passes, n_passes;
    logic [fwd_pkg::PAT_AW-1:0]        r_pat_idx, n_pat_idx;
    logic [fwd_pkg::PAT_CW-1:0]        r_pat_len, n_pat_len;
    logic [7:0]                        r_fill, n_fill;
    logic                              r_held_v, n_held_v;
    logic [7:0]                        r_held, n_held;
    logic                              r_in_par, n_in_par;
    logic [fwd_pkg::COUNT_BITS-1:0]    r_prod, n_prod;
    logic                              r_ended, n_ended;
    logic [fwd_pkg::LIMIT_BITS-1:0]    r_limit, n_limit;

    logic [fwd_pkg::COUNT_BITS-1:0]    prod_inc;
    logic                              cur_hit;
    logic                              inc_hit;
    logic [fwd_pkg::REM_BITS-1:0]      rem_dec;
    logic [fwd_pkg::PAT_CW-1:0]        pat_inc;
    logic                              pat_wrap;
    logic [fwd_pkg::PASS_BITS-1:0]     passes_dec;
    logic                              need_pad;
    logic                              live;
    logic                              feed_taken;
    logic                              feed_complete;
    logic                              pull_gives;
    logic                              pull_complete;
    logic                              deliver_end;
    logic [7:0]                        pull_byte;

    // Shared decode of the current state.
    always_comb begin
        prod_inc   = r_prod + 1'b1;
        cur_hit    = fwd_pkg::CMP_BITS'(r_prod) >= fwd_pkg::CMP_BITS'(r_limit);
        inc_hit    = fwd_pkg::CMP_BITS'(prod_inc) >= fwd_pkg::CMP_BITS'(r_limit);
        rem_dec    = r_rem - 1'b1;
        pat_inc    = fwd_pkg::PAT_CW'(r_pat_idx) + 1'b1;
        pat_wrap   = pat_inc >= r_pat_len;
        passes_dec = r_passes - 1'b1;
        // Parity is taken with the header byte already counted.
        need_pad   = ~r_in_par ^ r_prod[0];
        live       = (r_phase != fwd_pkg::PH_TRUNC) && (r_phase != fwd_pkg::PH_DONE)
                     && !cur_hit;

        feed_taken    = 1'b1;
        feed_complete = 1'b0;
        case (r_phase)
            fwd_pkg::PH_REP_PAT:   feed_complete = pat_wrap;
            fwd_pkg::PH_BLK_DATA: begin
                feed_taken    = !r_held_v;
                feed_complete = (r_rem == fwd_pkg::REM_BITS'(1));
            end
            fwd_pkg::PH_LR_VAL:    feed_complete = 1'b1;
            fwd_pkg::PH_SR_VAL:    feed_complete = 1'b1;
            fwd_pkg::PH_REP_EMIT:  feed_taken = 1'b0;
            fwd_pkg::PH_RUN_EMIT:  feed_taken = 1'b0;
            fwd_pkg::PH_DONE:      feed_taken = 1'b0;
            fwd_pkg::PH_TRUNC:     feed_taken = 1'b0;
            default:               feed_complete = 1'b0;
        endcase

        pull_gives    = 1'b0;
        pull_complete = 1'b0;
        pull_byte     = 8'd0;
        case (r_phase)
            fwd_pkg::PH_BLK_DATA: begin
                pull_gives    = r_held_v;
                pull_complete = (rem_dec == '0);
                pull_byte     = r_held;
            end
            fwd_pkg::PH_RUN_EMIT: begin
                pull_gives    = 1'b1;
                pull_complete = (rem_dec == '0);
                pull_byte     = r_fill;
            end
            fwd_pkg::PH_REP_EMIT: begin
                pull_gives    = 1'b1;
                pull_complete = pat_wrap ? (passes_dec == '0) : (r_passes == '0);
            end
            default:               pull_gives = 1'b0;
        endcase

        deliver_end = inc_hit || (pull_complete && r_ended);
    end

    // Next state.
    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_rem     = r_rem;
        n_passes  = r_passes;
        n_pat_idx = r_pat_idx;
        n_pat_len = r_pat_len;
        n_fill    = r_fill;
        n_held_v  = r_held_v;
        n_held    = r_held;
        n_in_par  = r_in_par;
        n_prod    = r_prod;
        n_ended   = r_ended;
        n_limit   = i_cfg_wr_en ? i_cfg_wr_data : r_limit;

        if (i_fire && r_phase != fwd_pkg::PH_TRUNC) begin
            if (!live) begin
                n_phase = fwd_pkg::PH_DONE;
            end else if (i_kind == fwd_pkg::KIND_FEED) begin
                if (feed_taken) begin
                    n_in_par = ~r_in_par;
                    case (r_phase)
                        fwd_pkg::PH_CMD: begin
                            n_cmd = i_in_byte;
                            case (i_in_byte[7:6])
                                fwd_pkg::CMD_REPEAT: begin
                                    n_pat_len = fwd_pkg::PAT_CW'(i_in_byte[5:0])
                                                + fwd_pkg::PAT_LEN_BIAS;
                                    n_phase   = fwd_pkg::PH_REP_COUNT;
                                end
                                fwd_pkg::CMD_BLOCK: begin
                                    if (i_in_byte[5]) begin
                                        n_rem   = fwd_pkg::REM_BITS'(i_in_byte[4:0])
                                                  + fwd_pkg::BLK_SHORT_BIAS;
                                        n_phase = need_pad ? fwd_pkg::PH_BLK_PAD
                                                           : fwd_pkg::PH_BLK_DATA;
                                    end else begin
                                        n_phase = fwd_pkg::PH_BLK_LEN;
                                    end
                                end
                                fwd_pkg::CMD_LRUN: n_phase = fwd_pkg::PH_LR_LEN;
                                fwd_pkg::CMD_SRUN: begin
                                    n_rem   = fwd_pkg::REM_BITS'(i_in_byte[5:0])
                                              + fwd_pkg::SRUN_BIAS;
                                    n_phase = fwd_pkg::PH_SR_VAL;
                                end
                                default: n_phase = fwd_pkg::PH_CMD;
                            endcase
                        end
                        fwd_pkg::PH_REP_COUNT: begin
                            n_passes  = fwd_pkg::PASS_BITS'(i_in_byte) + fwd_pkg::PASS_BIAS;
                            n_pat_idx = '0;
                            n_phase   = fwd_pkg::PH_REP_PAT;
                        end
                        fwd_pkg::PH_REP_PAT: begin
                            if (pat_wrap) begin
                                n_pat_idx = '0;
                                n_phase   = fwd_pkg::PH_REP_EMIT;
                            end else begin
                                n_pat_idx = pat_inc[fwd_pkg::PAT_AW-1:0];
                            end
                        end
                        fwd_pkg::PH_BLK_LEN: begin
                            n_rem   = fwd_pkg::REM_BITS'({r_cmd[4:0], i_in_byte})
                                      + fwd_pkg::BLK_LONG_BIAS;
                            n_phase = need_pad ? fwd_pkg::PH_BLK_PAD : fwd_pkg::PH_BLK_DATA;
                        end
                        fwd_pkg::PH_BLK_PAD: n_phase = fwd_pkg::PH_BLK_DATA;
                        fwd_pkg::PH_BLK_DATA: begin
                            n_held_v = 1'b1;
                            n_held   = {i_in_byte[4:0], i_in_byte[7:5]};
                        end
                        fwd_pkg::PH_LR_LEN: begin
                            n_rem   = fwd_pkg::REM_BITS'({r_cmd[5:0], i_in_byte})
                                      + fwd_pkg::LRUN_BIAS;
                            n_phase = fwd_pkg::PH_LR_VAL;
                        end
                        fwd_pkg::PH_LR_VAL: begin
                            n_fill  = {i_in_byte[2:0], i_in_byte[7:3]};
                            n_phase = fwd_pkg::PH_RUN_EMIT;
                        end
                        fwd_pkg::PH_SR_VAL: begin
                            n_fill  = {i_in_byte[1:0], i_in_byte[7:2]};
                            n_phase = fwd_pkg::PH_RUN_EMIT;
                        end
                        default: n_phase = r_phase;
                    endcase
                    if (i_in_last) begin
                        if (!feed_complete) begin
                            n_phase  = fwd_pkg::PH_TRUNC;
                            n_held_v = 1'b0;
                        end else begin
                            n_ended = 1'b1;
                        end
                    end
                end
            end else if (pull_gives) begin
                n_prod = prod_inc;
                case (r_phase)
                    fwd_pkg::PH_BLK_DATA: begin
                        n_held_v = 1'b0;
                        n_rem    = rem_dec;
                    end
                    fwd_pkg::PH_RUN_EMIT: n_rem = rem_dec;
                    fwd_pkg::PH_REP_EMIT: begin
                        if (pat_wrap) begin
                            n_pat_idx = '0;
                            n_passes  = passes_dec;
                        end else begin
                            n_pat_idx = pat_inc[fwd_pkg::PAT_AW-1:0];
                        end
                    end
                    default: n_rem = r_rem;
                endcase
                if (deliver_end) begin
                    n_phase = fwd_pkg::PH_DONE;
                end else if (pull_complete) begin
                    n_phase = fwd_pkg::PH_CMD;
                end
            end
        end
    end

    // Result and memory access of the item.
    always_comb begin
        o_res           = '0;
        o_res.status    = fwd_pkg::ST_OK;
        o_mem.wr_en     = i_fire && live && (i_kind == fwd_pkg::KIND_FEED)
                          && (r_phase == fwd_pkg::PH_REP_PAT);
        o_mem.rd_en     = i_fire && live && (i_kind == fwd_pkg::KIND_PULL)
                          && (r_phase == fwd_pkg::PH_REP_EMIT);
        o_mem.addr      = r_pat_idx;
        o_mem.wr_data   = i_in_byte;

        if (r_phase == fwd_pkg::PH_TRUNC) begin
            o_res.status = fwd_pkg::ST_TRUNC;
        end else if (!live) begin
            o_res.status = fwd_pkg::ST_DONE;
        end else if (i_kind == fwd_pkg::KIND_FEED) begin
            if (!feed_taken) begin
                o_res.status = fwd_pkg::ST_PEND;
            end else if (i_in_last && !feed_complete) begin
                o_res.status = fwd_pkg::ST_TRUNC;
            end
        end else if (!pull_gives) begin
            o_res.status = fwd_pkg::ST_NEED;
        end else begin
            o_res.byte_val  = pull_byte;
            o_res.use_mem   = (r_phase == fwd_pkg::PH_REP_EMIT);
            o_res.out_valid = 1'b1;
            o_res.out_last  = deliver_end;
            o_res.status    = deliver_end ? fwd_pkg::ST_DONE : fwd_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= fwd_pkg::PH_CMD;
            r_cmd     <= '0;
            r_rem     <= '0;
            r_passes  <= '0;
            r_pat_idx <= '0;
            r_pat_len <= '0;
            r_fill    <= '0;
            r_held_v  <= 1'b0;
            r_held    <= '0;
            r_in_par  <= 1'b0;
            r_prod    <= '0;
            r_ended   <= 1'b0;
            r_limit   <= fwd_pkg::LIMIT_RESET;
        end else begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_rem     <= n_rem;
            r_passes  <= n_passes;
            r_pat_idx <= n_pat_idx;
            r_pat_len <= n_pat_len;
            r_fill    <= n_fill;
            r_held_v  <= n_held_v;
            r_held    <= n_held;
            r_in_par  <= n_in_par;
            r_prod    <= n_prod;
            r_ended   <= n_ended;
            r_limit   <= n_limit;
        end
    end

endmodule
`default_nettype wire

[hdl/firmware_stream_decompressor.sv]
// Firmware stream decompressor: top level with result pipeline and checks.
//
// Input channel (i_item_valid) carries one item per cycle while o_item_stall
// is low: i_kind 0 feeds the compressed byte i_in_byte (i_in_last marks the
// end of the stream), i_kind 1 pulls the next decompressed byte. Every item
// yields exactly one result on the result channel (o_res_valid / i_res_stall):
// o_out_byte, o_out_valid, o_out_last and o_status.
// From acceptance the result passes the middle stage, which takes the state
// update and the pattern memory read, and then the output register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single read-modify-write of the stream state and at most one pattern
// memory port access per item.
// When the receiver stalls, the result holds in the output register and one
// more item may be taken into the middle stage; after that o_item_stall rises
// until the output drains. The user writes the output limit (i_cfg_wr_en /
// i_cfg_wr_data) only while idle; the block itself does not enforce this.
// Synchronous reset (i_rst_n low) empties the pipeline, returns the decoder
// to waiting for a command byte, clears the byte count and sets the limit to
// its maximum. The pattern memory needs no clearing.
`default_nettype none
`include "assert_macros.svh"
module firmware_stream_decompressor (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_item_valid,
    output logic                                 o_item_stall,
    input  wire logic                            i_kind,
    input  wire logic [7:0]                      i_in_byte,
    input  wire logic                            i_in_last,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_stall,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_out_valid,
    output logic                                 o_out_last,
    output logic [2:0]                           o_status,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [fwd_pkg::LIMIT_BITS-1:0]  i_cfg_wr_data
);

    logic              fire;
    logic              s1_adv;
    fwd_pkg::t_result  w_res;
    fwd_pkg::t_mem_req w_mem;
    logic [7:0]        w_rdata;

    logic              r_s1_v;
    fwd_pkg::t_result  r_s1;
    logic              r_o_v;
    logic [7:0]        r_o_byte;
    logic              r_o_valid;
    logic              r_o_last;
    fwd_pkg::t_status  r_o_status;

    always_comb begin
        s1_adv       = r_s1_v && (!r_o_v || !i_res_stall);
        o_item_stall = r_s1_v && !s1_adv;
        fire         = i_item_valid && !o_item_stall;
    end

    fwd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_kind        (i_kind),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res         (w_res),
        .o_mem         (w_mem)
    );

    fwd_pat_ram #(
        .DEPTH (fwd_pkg::PAT_DEPTH),
        .WIDTH (8)
    ) u_pat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem.wr_en),
        .i_wr_addr (w_mem.addr),
        .i_wr_data (w_mem.wr_data),
        .i_rd_en   (w_mem.rd_en),
        .i_rd_addr (w_mem.addr),
        .o_rd_data (w_rdata)
    );

    // Middle stage: holds the item result while the memory read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (fire) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1 <= w_res;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s1_adv) begin
            r_o_v <= 1'b1;
        end else if (!i_res_stall) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_byte   <= r_s1.use_mem ? w_rdata : r_s1.byte_val;
            r_o_valid  <= r_s1.out_valid;
            r_o_last   <= r_s1.out_last;
            r_o_status <= r_s1.status;
        end
    end

    assign o_res_valid = r_o_v;
    assign o_out_byte  = r_o_byte;
    assign o_out_valid = r_o_valid;
    assign o_out_last  = r_o_last;
    assign o_status    = r_o_status;

    `ASSERT_IMPLY(a_byte_status, i_clk, i_rst_n, o_res_valid && o_out_valid, o_status == fwd_pkg::ST_OK || o_status == fwd_pkg::ST_DONE)
    `ASSERT_IMPLY(a_last_done, i_clk, i_rst_n, o_res_valid && o_out_last, o_out_valid && o_status == fwd_pkg::ST_DONE)
    `ASSERT_NEXT(a_rdata_hold, i_clk, i_rst_n, r_s1_v && r_s1.use_mem && !s1_adv, $stable(w_rdata))

endmodule
`default_nettype wire
